// ===== design/lsol_pkg.sv =====
// Shared payload types and fixed field widths for the 3x3 linear solver.
package lsol_pkg;

   localparam int DATA_W = 32;

   typedef struct packed {
      logic signed [DATA_W-1:0] m_r1c1;
      logic signed [DATA_W-1:0] m_r1c2;
      logic signed [DATA_W-1:0] m_r1c3;
      logic signed [DATA_W-1:0] m_r2c1;
      logic signed [DATA_W-1:0] m_r2c2;
      logic signed [DATA_W-1:0] m_r2c3;
      logic signed [DATA_W-1:0] m_r3c1;
      logic signed [DATA_W-1:0] m_r3c2;
      logic signed [DATA_W-1:0] m_r3c3;
      logic signed [DATA_W-1:0] rhs_1;
      logic signed [DATA_W-1:0] rhs_2;
      logic signed [DATA_W-1:0] rhs_3;
   } req_payload_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] sol_1;
      logic signed [DATA_W-1:0] sol_2;
      logic signed [DATA_W-1:0] sol_3;
      logic signed [DATA_W-1:0] det_value;
      logic                     singular;
   } rsp_payload_type;

endpackage

// ===== design/linear_solve_3x3_unit.sv =====
// Top level: 3x3 linear solve by adjugate and determinant, three division lanes merged.
//
//  channel | ports                        | beat taken when
//  --------+------------------------------+-----------------------
//  request | start, busy, req_data        | start && !busy
//  result  | rsp_strobe, rsp_data         | rsp_strobe (one cycle)
//
// One system accepted every cycle; busy stays low.
// The result path runs through the quotient stages of the division lanes, one quotient
// bit per stage.
// Synchronous reset clears the valid pipeline only; no result is lost to stalls as
// the receiver always takes the strobed beat.
module linear_solve_3x3_unit #(
   parameter int FRAC_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  lsol_pkg::req_payload_type req_data,
   output logic                      rsp_strobe,
   output lsol_pkg::rsp_payload_type rsp_data
);

   localparam int W        = lsol_pkg::DATA_W;
   localparam int PW       = 2 * W;
   localparam int ADJW     = 2 * W + 1;
   localparam int MW       = ADJW + W;
   localparam int SW       = 3 * W + 2;
   localparam int LANE_LAT = W + 3;
   localparam int TOTAL    = 7 + LANE_LAT;

   localparam int unsigned ADJ_A [9] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
   localparam int unsigned ADJ_B [9] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
   localparam int unsigned ADJ_C [9] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
   localparam int unsigned ADJ_D [9] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

   lsol_pkg::req_payload_type in_ff;
   logic                      vld_ff [TOTAL];

   logic signed [W-1:0]    m     [9];
   logic signed [W-1:0]    b     [3];
   logic signed [PW-1:0]   pa_ff [9];
   logic signed [PW-1:0]   pb_ff [9];
   logic signed [ADJW-1:0] adj_ff [9];
   logic signed [W-1:0]    m1b_ff [3];
   logic signed [W-1:0]    bb_ff  [3];
   logic signed [W-1:0]    m1c_ff [3];
   logic signed [W-1:0]    bc_ff  [3];
   logic signed [MW-1:0]   prod  [4][3];
   logic signed [SW-1:0]   acc_ff [4];
   logic signed [W-1:0]    sol   [3];

   logic [SW-1:0]        dmag;
   logic [SW-1:0]        dshr;
   logic signed [W-1:0]  dval_in;
   logic signed [W-1:0]  dval_ff [LANE_LAT];
   logic                 sing_ff [LANE_LAT];

   lsol_pkg::rsp_payload_type rsp_in, rsp_ff;

   assign busy = 1'b0;

   // valid pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TOTAL; i++) vld_ff[i] <= 1'b0;
      end else begin
         vld_ff[0] <= start && !busy;
         for (int i = 1; i < TOTAL; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      in_ff <= req_data;
   end

   assign m[0] = in_ff.m_r1c1;
   assign m[1] = in_ff.m_r1c2;
   assign m[2] = in_ff.m_r1c3;
   assign m[3] = in_ff.m_r2c1;
   assign m[4] = in_ff.m_r2c2;
   assign m[5] = in_ff.m_r2c3;
   assign m[6] = in_ff.m_r3c1;
   assign m[7] = in_ff.m_r3c2;
   assign m[8] = in_ff.m_r3c3;
   assign b[0] = in_ff.rhs_1;
   assign b[1] = in_ff.rhs_2;
   assign b[2] = in_ff.rhs_3;

   // cofactor products, then adjugate
   always_ff @(posedge clock) begin
      for (int k = 0; k < 9; k++) begin
         pa_ff[k]  <= m[ADJ_A[k]] * m[ADJ_B[k]];
         pb_ff[k]  <= m[ADJ_C[k]] * m[ADJ_D[k]];
         adj_ff[k] <= ADJW'(pa_ff[k]) - ADJW'(pb_ff[k]);
      end
      for (int t = 0; t < 3; t++) begin
         m1b_ff[t] <= m[t];
         bb_ff[t]  <= b[t];
         m1c_ff[t] <= m1b_ff[t];
         bc_ff[t]  <= bb_ff[t];
      end
   end

   // lanes 0..2 form adj row times rhs, lane 3 the determinant along row one
   for (genvar j = 0; j < 4; j++) begin : g_mac
      for (genvar t = 0; t < 3; t++) begin : g_term
         if (j < 3) begin : g_sum
            lsol_wmul #(.AW(ADJW), .BW(W)) u_mul (
               .clock (clock),
               .a     (adj_ff[3*j+t]),
               .b     (bc_ff[t]),
               .p     (prod[j][t])
            );
         end else begin : g_det
            lsol_wmul #(.AW(ADJW), .BW(W)) u_mul (
               .clock (clock),
               .a     (adj_ff[3*t]),
               .b     (m1c_ff[t]),
               .p     (prod[j][t])
            );
         end
      end
      always_ff @(posedge clock) begin
         acc_ff[j] <= SW'(prod[j][0]) + SW'(prod[j][1]) + SW'(prod[j][2]);
      end
   end

   for (genvar j = 0; j < 3; j++) begin : g_lane
      lsol_div_lane #(.SW(SW), .FRAC_BITS(FRAC_BITS)) u_lane (
         .clock (clock),
         .num   (acc_ff[j]),
         .den   (acc_ff[3]),
         .quo   (sol[j])
      );
   end

   // determinant at data format, toward zero, saturated; hold alongside the lanes
   assign dmag = acc_ff[3][SW-1] ? SW'(-acc_ff[3]) : acc_ff[3];
   assign dshr = dmag >> (2 * FRAC_BITS);

   always_comb begin
      if (dshr >= (SW'(1) << (W - 1))) begin
         dval_in = acc_ff[3][SW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end else begin
         dval_in = acc_ff[3][SW-1] ? W'(-dshr) : W'(dshr);
      end
   end

   always_ff @(posedge clock) begin
      dval_ff[0] <= dval_in;
      sing_ff[0] <= (acc_ff[3] == '0);
      for (int i = 1; i < LANE_LAT; i++) begin
         dval_ff[i] <= dval_ff[i-1];
         sing_ff[i] <= sing_ff[i-1];
      end
   end

   // merge lanes; force zeros on a singular matrix
   always_comb begin
      rsp_in.singular = sing_ff[LANE_LAT-1];
      if (sing_ff[LANE_LAT-1]) begin
         rsp_in.sol_1     = '0;
         rsp_in.sol_2     = '0;
         rsp_in.sol_3     = '0;
         rsp_in.det_value = '0;
      end else begin
         rsp_in.sol_1     = sol[0];
         rsp_in.sol_2     = sol[1];
         rsp_in.sol_3     = sol[2];
         rsp_in.det_value = dval_ff[LANE_LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = vld_ff[TOTAL-1];
   assign rsp_data   = rsp_ff;

endmodule

// ===== design/lsol_wmul.sv =====
// Two-stage signed multiplier: wide operand split in halves, partials summed in stage two.
module lsol_wmul #(
   parameter int AW = 65,
   parameter int BW = 32
) (
   input  logic                  clock,
   input  logic signed [AW-1:0]  a,
   input  logic signed [BW-1:0]  b,
   output logic signed [AW+BW-1:0] p
);

   localparam int HALF = AW / 2;
   localparam int HW   = AW - HALF;
   localparam int LW   = HALF + 1 + BW;
   localparam int PW   = AW + BW;

   logic signed [LW-1:0]      lo_in, lo_ff;
   logic signed [HW+BW-1:0]   hi_in, hi_ff;
   logic signed [PW-1:0]      p_in, p_ff;

   assign lo_in = $signed({1'b0, a[HALF-1:0]}) * b;
   assign hi_in = $signed(a[AW-1:HALF]) * b;
   assign p_in  = (PW'(hi_ff) <<< HALF) + PW'(lo_ff);

   always_ff @(posedge clock) begin
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      p_ff  <= p_in;
   end

   assign p = p_ff;

endmodule

// ===== design/lsol_div_lane.sv =====
// One division lane: (num << FRAC_BITS) / den, toward zero, saturated, one quotient bit a stage.
module lsol_div_lane #(
   parameter int SW        = 98,
   parameter int FRAC_BITS = 16
) (
   input  logic                                 clock,
   input  logic signed [SW-1:0]                 num,
   input  logic signed [SW-1:0]                 den,
   output logic signed [lsol_pkg::DATA_W-1:0]   quo
);

   localparam int W   = lsol_pkg::DATA_W;
   localparam int NW  = SW + FRAC_BITS;
   localparam int DSH = SW + W;
   localparam int CW  = (NW > DSH) ? NW : DSH;

   logic signed [NW-1:0] n_ext;
   logic [NW-1:0]        nmag_in, nmag_ff;
   logic [SW-1:0]        dmag_in, dmag_ff;
   logic                 neg_ff;

   logic [NW-1:0] r_ff   [W+1];
   logic [W-1:0]  q_ff   [W+1];
   logic [SW-1:0] d_ff   [W+1];
   logic          sgn_ff [W+1];
   logic          ovf_ff [W+1];

   logic [W-1:0]          q_fin;
   logic signed [W-1:0]   quo_in, quo_ff;

   assign n_ext   = NW'(num) <<< FRAC_BITS;
   assign nmag_in = n_ext[NW-1] ? NW'(-n_ext) : n_ext;
   assign dmag_in = den[SW-1] ? SW'(-den) : den;

   always_ff @(posedge clock) begin
      nmag_ff   <= nmag_in;
      dmag_ff   <= dmag_in;
      neg_ff    <= n_ext[NW-1] ^ den[SW-1];
      // quotient of more than W bits cannot fit: flag it now
      ovf_ff[0] <= CW'(nmag_ff) >= (CW'(dmag_ff) << W);
      r_ff[0]   <= nmag_ff;
      q_ff[0]   <= '0;
      d_ff[0]   <= dmag_ff;
      sgn_ff[0] <= neg_ff;
   end

   for (genvar k = 0; k < W; k++) begin : g_step
      localparam int SH = W - 1 - k;
      logic [CW-1:0] trial;
      logic          ge;
      assign trial = CW'(d_ff[k]) << SH;
      assign ge    = CW'(r_ff[k]) >= trial;
      always_ff @(posedge clock) begin
         r_ff[k+1]   <= ge ? NW'(CW'(r_ff[k]) - trial) : r_ff[k];
         q_ff[k+1]   <= {q_ff[k][W-2:0], ge};
         d_ff[k+1]   <= d_ff[k];
         sgn_ff[k+1] <= sgn_ff[k];
         ovf_ff[k+1] <= ovf_ff[k];
      end
   end

   assign q_fin = q_ff[W];

   always_comb begin
      if (ovf_ff[W]) begin
         quo_in = sgn_ff[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end else if (sgn_ff[W]) begin
         quo_in = (q_fin[W-1] && (q_fin[W-2:0] != '0)) ? {1'b1, {(W-1){1'b0}}}
                                                      : W'(-q_fin);
      end else begin
         quo_in = q_fin[W-1] ? {1'b0, {(W-1){1'b1}}} : q_fin;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
   end

   assign quo = quo_ff;

endmodule

// ===== design/lsol_checker.sv =====
// Port-level checks for the 3x3 linear solver, bound to the top level.
module lsol_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      start,
   input logic                      busy,
   input lsol_pkg::rsp_payload_type rsp_data,
   input logic                      rsp_strobe
);

   a_never_busy : assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");

   a_singular_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.singular) |->
         (rsp_data.sol_1 == '0 && rsp_data.sol_2 == '0 &&
          rsp_data.sol_3 == '0 && rsp_data.det_value == '0))
      else $error("singular result with nonzero fields");

   a_quiet_after_reset : assert property (@(posedge clock) reset |=> !rsp_strobe)
      else $error("result strobe straight after reset");

   a_start_seen : assert property (@(posedge clock) disable iff (reset)
      (start && $past(reset)) |-> !busy)
      else $error("first beat after reset refused");

endmodule

bind linear_solve_3x3_unit lsol_checker u_lsol_checker (.*);
